// ===== rtl/qec_pkg.sv =====
package qec_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int NUM_ENCODERS = 4;
   localparam int OUT_WIDTH = 32;
   localparam int TIME_WIDTH = 32;
   localparam int INTERVAL_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REVERSE_MASK = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STREAM_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPORT_INTERVAL = 2'd2;

   localparam logic [NUM_ENCODERS-1:0] RESET_REVERSE = 4'd10;
   localparam logic [INTERVAL_WIDTH-1:0] RESET_INTERVAL = 16'd50;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } step_type;

   typedef enum logic [1:0] {
      REPORT_NONE   = 2'd0,
      REPORT_READ   = 2'd1,
      REPORT_STREAM = 2'd2
   } report_kind_type;

   typedef struct packed {
      logic advance;
      logic primed;
      logic clear;
      logic reverse;
   } chan_ctrl_type;

   // x4 decode: old phase (a,b) in the upper two bits, new phase below
   function automatic step_type step_of(input logic [3:0] trans);
      step_type s;
      unique case (trans)
         4'h1, 4'h7, 4'h8, 4'he: s = STEP_UP;
         4'h2, 4'h4, 4'hb, 4'hd: s = STEP_DOWN;
         default:                s = STEP_NONE;
      endcase
      return s;
   endfunction

   localparam int EXT_WIDTH = COUNT_WIDTH + OUT_WIDTH;

   // sign-extend narrow counts, keep the low bits of wide ones
   function automatic logic [OUT_WIDTH-1:0] count_out(input logic [COUNT_WIDTH-1:0] c);
      logic [EXT_WIDTH-1:0] ext;
      ext = {{OUT_WIDTH{c[COUNT_WIDTH-1]}}, c};
      return ext[OUT_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/qec_req_if.sv =====
interface qec_req_if;
   import qec_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [NUM_ENCODERS-1:0] phase_a;
   logic [NUM_ENCODERS-1:0] phase_b;
   logic                    clear_counts;
   logic                    read_request;
   logic                    ms_tick;

   modport source (
      output valid, phase_a, phase_b, clear_counts, read_request, ms_tick,
      input  ready
   );

   modport sink (
      input  valid, phase_a, phase_b, clear_counts, read_request, ms_tick,
      output ready
   );
endinterface

// ===== rtl/qec_rsp_if.sv =====
interface qec_rsp_if;
   import qec_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [OUT_WIDTH-1:0]  lf_count;
   logic signed [OUT_WIDTH-1:0]  rf_count;
   logic signed [OUT_WIDTH-1:0]  lr_count;
   logic signed [OUT_WIDTH-1:0]  rr_count;
   logic [1:0]                   report_kind;
   logic [TIME_WIDTH-1:0]        stamp_ms;

   modport source (
      output valid, lf_count, rf_count, lr_count, rr_count, report_kind, stamp_ms,
      input  ready
   );

   modport sink (
      input  valid, lf_count, rf_count, lr_count, rr_count, report_kind, stamp_ms,
      output ready
   );
endinterface

// ===== rtl/qec_channel.sv =====
module qec_channel (
   input  logic                              clock,
   input  logic                              reset,
   input  qec_pkg::chan_ctrl_type            ctrl,
   input  logic [1:0]                        phase,
   output logic [qec_pkg::COUNT_WIDTH-1:0]   count_next
);
   import qec_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [1:0]             last_phase_ff;
   step_type               step;
   step_type               dir;

   always_comb begin
      step = step_of({last_phase_ff, phase});
      dir = step;
      if (ctrl.reverse) begin
         unique case (step)
            STEP_UP:   dir = STEP_DOWN;
            STEP_DOWN: dir = STEP_UP;
            default:   dir = STEP_NONE;
         endcase
      end
   end

   always_comb begin
      count_next = count_ff;
      if (ctrl.primed) begin
         unique case (dir)
            STEP_UP:   count_next = count_ff + COUNT_WIDTH'(1);
            STEP_DOWN: count_next = count_ff - COUNT_WIDTH'(1);
            default:   count_next = count_ff;
         endcase
      end
      if (ctrl.clear) begin
         count_next = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.advance) begin
         count_ff <= count_next;
      end
   end

   // first sample only loads the phase, so no reset needed here
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         last_phase_ff <= phase;
      end
   end

endmodule

// ===== rtl/quad_encoder_counter_bank.sv =====
// channel   direction  handshake          payload
// req_port  in         valid / ready      phase_a, phase_b, clear_counts, read_request, ms_tick
// rsp_port  out        valid / ready      four counts, report_kind, stamp_ms
// csr_*     in         write enable only  csr_index, csr_write_data
//
// one transaction per cycle unless rsp_port stalls; a result reaches rsp_port after its request
// is taken (input register, then the count / report logic into the result register)
// synchronous reset clears counts, time, priming and the registers to their defaults
// a stalled result holds the pipe; the input register still takes a transaction
// whenever it is empty or the one it holds can move into the result register
module quad_encoder_counter_bank (
   input  logic                                  clock,
   input  logic                                  reset,
   qec_req_if.sink                               req_port,
   qec_rsp_if.source                             rsp_port,
   input  logic                                  csr_write_enable,
   input  logic [qec_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [qec_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import qec_pkg::*;

   // config
   logic [NUM_ENCODERS-1:0]   reverse_mask_ff;
   logic                      stream_enable_ff;
   logic [INTERVAL_WIDTH-1:0] interval_ff;

   // input register
   logic                      s1_valid_ff;
   logic [NUM_ENCODERS-1:0]   s1_phase_a_ff;
   logic [NUM_ENCODERS-1:0]   s1_phase_b_ff;
   logic                      s1_clear_ff;
   logic                      s1_read_ff;
   logic                      s1_tick_ff;

   // block state
   logic                      primed_ff;
   logic [TIME_WIDTH-1:0]     time_ff;
   logic [TIME_WIDTH-1:0]     time_in;
   logic [TIME_WIDTH-1:0]     last_report_ff;
   logic [TIME_WIDTH-1:0]     last_report_in;
   logic [TIME_WIDTH-1:0]     elapsed;

   // result register
   logic                      out_valid_ff;
   logic [OUT_WIDTH-1:0]      out_count_ff [NUM_ENCODERS];
   report_kind_type           out_kind_ff;
   report_kind_type           kind;
   logic [TIME_WIDTH-1:0]     out_time_ff;

   logic                      out_load;
   logic                      advance;
   logic [COUNT_WIDTH-1:0]    count_next [NUM_ENCODERS];

   assign out_load = !out_valid_ff || rsp_port.ready;
   assign advance = s1_valid_ff && out_load;
   assign req_port.ready = !s1_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.ready && req_port.valid) begin
         s1_phase_a_ff <= req_port.phase_a;
         s1_phase_b_ff <= req_port.phase_b;
         s1_clear_ff <= req_port.clear_counts;
         s1_read_ff <= req_port.read_request;
         s1_tick_ff <= req_port.ms_tick;
      end
   end

   for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_chan
      chan_ctrl_type ctrl;
      assign ctrl = '{advance: advance, primed: primed_ff, clear: s1_clear_ff,
                      reverse: reverse_mask_ff[i]};
      qec_channel u_chan (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .phase      ({s1_phase_a_ff[i], s1_phase_b_ff[i]}),
         .count_next (count_next[i])
      );
   end

   always_comb begin
      time_in = time_ff + TIME_WIDTH'(s1_tick_ff);
      elapsed = time_in - last_report_ff;
      kind = REPORT_NONE;
      last_report_in = last_report_ff;
      priority if (s1_read_ff) begin
         kind = REPORT_READ;
         last_report_in = time_in;
      end else if (stream_enable_ff &&
                   elapsed >= TIME_WIDTH'(interval_ff)) begin
         kind = REPORT_STREAM;
         last_report_in = time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         time_ff <= '0;
         last_report_ff <= '0;
      end else if (advance) begin
         primed_ff <= 1'b1;
         time_ff <= time_in;
         last_report_ff <= last_report_in;
      end else if (csr_write_enable && csr_index == CSR_STREAM_ENABLE) begin
         // a write to stream enable restarts the interval unless a transaction advances in the same cycle
         last_report_ff <= time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_mask_ff <= RESET_REVERSE;
         stream_enable_ff <= 1'b0;
         interval_ff <= RESET_INTERVAL;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REVERSE_MASK:    reverse_mask_ff <= csr_write_data[NUM_ENCODERS-1:0];
            CSR_STREAM_ENABLE:   stream_enable_ff <= csr_write_data[0];
            CSR_REPORT_INTERVAL: interval_ff <= csr_write_data[INTERVAL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_ENCODERS; i++) begin
            out_count_ff[i] <= count_out(count_next[i]);
         end
         out_kind_ff <= kind;
         out_time_ff <= time_in;
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.lf_count = out_count_ff[0];
   assign rsp_port.rf_count = out_count_ff[1];
   assign rsp_port.lr_count = out_count_ff[2];
   assign rsp_port.rr_count = out_count_ff[3];
   assign rsp_port.report_kind = out_kind_ff;
   assign rsp_port.stamp_ms = out_time_ff;

`ifndef SYNTHESIS
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (time_ff == $past(time_ff) || time_ff == $past(time_ff) + TIME_WIDTH'(1)))
      else $error("time advanced by more than one tick");

   a_primed_source: assert property (@(posedge clock) disable iff (reset)
      $rose(primed_ff) |-> $past(advance))
      else $error("primed without a transaction");

   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_read_ff) |=> (out_valid_ff && out_kind_ff == REPORT_READ))
      else $error("read request did not produce a read reply");

   a_report_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && kind != REPORT_NONE) |=> (last_report_ff == time_ff &&
                                           out_time_ff == time_ff))
      else $error("report did not restart the interval");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_kind_ff == REPORT_NONE || out_kind_ff == REPORT_READ ||
                        out_kind_ff == REPORT_STREAM))
      else $error("illegal report kind");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import qec_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int MAX_IDLE = 6;
   localparam int QUIET_LIMIT = 300;
   localparam int PIPE_LATENCY = 2;
   localparam int MOTION_PHASES = 8;
   localparam int MOTION_ITEMS = 228;

   typedef struct packed {
      logic [NUM_ENCODERS-1:0] phase_a;
      logic [NUM_ENCODERS-1:0] phase_b;
      logic                    clear_counts;
      logic                    read_request;
      logic                    ms_tick;
   } encoder_sample_type;

   typedef struct packed {
      logic [NUM_ENCODERS-1:0][OUT_WIDTH-1:0] count;
      report_kind_type                        kind;
      logic [TIME_WIDTH-1:0]                  stamp;
   } count_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   qec_req_if req_if ();
   qec_rsp_if rsp_if ();

   quad_encoder_counter_bank DUT (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if),
      .rsp_port         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // encoder bank state as the block should hold it
   logic [NUM_ENCODERS-1:0]   rev_mask = RESET_REVERSE;
   logic                      stream_on = 1'b0;
   logic [INTERVAL_WIDTH-1:0] interval_ms = RESET_INTERVAL;
   logic [COUNT_WIDTH-1:0]    pos_count [NUM_ENCODERS] = '{default: '0};
   logic [1:0]                prev_phase [NUM_ENCODERS] = '{default: '0};
   logic                      phases_primed = 1'b0;
   logic [TIME_WIDTH-1:0]     ms_time = '0;
   logic [TIME_WIDTH-1:0]     last_report_ms = '0;

   count_report_type pending_reports [$];

   bit    sender_idles = 1'b0;
   bit    sink_idles = 1'b0;
   int    failures = 0;
   int    samples_sent = 0;
   int    reports_checked = 0;
   int    csr_writes = 0;
   int    quiet_cycles = 0;
   int    kind_tally [4] = '{default: 0};
   string wheel_name [NUM_ENCODERS] = '{"lf", "rf", "lr", "rr"};

   // gray code position along the x4 cycle 00 -> 01 -> 11 -> 10; the map is its own inverse
   function automatic logic [1:0] quad_position(input logic [1:0] p);
      return {p[1], p[1] ^ p[0]};
   endfunction

   function automatic count_report_type decode_sample(input encoder_sample_type s);
      count_report_type      rep;
      logic [1:0]            now;
      logic [1:0]            moved;
      logic [TIME_WIDTH-1:0] elapsed;
      if (s.ms_tick) ms_time = ms_time + 1'b1;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
         now = {s.phase_a[i], s.phase_b[i]};
         moved = quad_position(now) - quad_position(prev_phase[i]);
         // a jump of two positions is a double-bit change and does not count
         if (phases_primed && (moved == 2'd1 || moved == 2'd3)) begin
            if ((moved == 2'd1) != rev_mask[i]) pos_count[i] = pos_count[i] + 1'b1;
            else pos_count[i] = pos_count[i] - 1'b1;
         end
         prev_phase[i] = now;
      end
      phases_primed = 1'b1;
      if (s.clear_counts)
         for (int i = 0; i < NUM_ENCODERS; i++) pos_count[i] = '0;
      elapsed = ms_time - last_report_ms;
      rep.kind = REPORT_NONE;
      if (s.read_request) begin
         rep.kind = REPORT_READ;
         last_report_ms = ms_time;
      end else if (stream_on && elapsed >= interval_ms) begin
         rep.kind = REPORT_STREAM;
         last_report_ms = ms_time;
      end
      for (int i = 0; i < NUM_ENCODERS; i++) rep.count[i] = OUT_WIDTH'(signed'(pos_count[i]));
      rep.stamp = ms_time;
      return rep;
   endfunction

   // mostly legal quadrature motion with random content, some noise
   function automatic encoder_sample_type make_motion_sample();
      encoder_sample_type s;
      logic [1:0]         pos;
      logic [1:0]         ph;
      int                 roll;
      s.phase_a = 4'($urandom);
      s.phase_b = 4'($urandom);
      s.clear_counts = 1'($urandom);
      s.read_request = 1'($urandom);
      s.ms_tick = 1'($urandom);
      if ($urandom_range(0, 99) >= 6) begin
         for (int i = 0; i < NUM_ENCODERS; i++) begin
            pos = quad_position(prev_phase[i]);
            roll = $urandom_range(0, 99);
            if (roll < 40) pos = pos + 1'b1;
            else if (roll < 70) pos = pos - 1'b1;
            else if (roll >= 85) pos = 2'($urandom);
            ph = quad_position(pos);
            s.phase_a[i] = ph[1];
            s.phase_b[i] = ph[0];
         end
         s.clear_counts = ($urandom_range(0, 99) < 2);
         s.read_request = ($urandom_range(0, 99) < 10);
         s.ms_tick = 1'($urandom_range(0, 1));
      end
      return s;
   endfunction

   task automatic send_sample(input encoder_sample_type s);
      int gap;
      bit hit;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.phase_a <= s.phase_a;
      req_if.phase_b <= s.phase_b;
      req_if.clear_counts <= s.clear_counts;
      req_if.read_request <= s.read_request;
      req_if.ms_tick <= s.ms_tick;
      hit = 1'b0;
      while (!hit) begin
         @(negedge clock);
         hit = req_if.ready;
         @(posedge clock);
      end
      pending_reports.push_back(decode_sample(s));
      samples_sent++;
   endtask

   task automatic wait_for_reports();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_REVERSE_MASK: rev_mask = data[NUM_ENCODERS-1:0];
         CSR_STREAM_ENABLE: begin
            stream_on = data[0];
            last_report_ms = ms_time;
         end
         CSR_REPORT_INTERVAL: interval_ms = data[INTERVAL_WIDTH-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // every old/new phase pair appears once in this cyclic walk
   localparam logic [31:0] PHASE_WALK = {2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3,
                                         2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1};

   task automatic test_transition_table();
      encoder_sample_type s;
      logic [1:0]         ph;
      for (int j = 0; j <= 16; j++) begin
         for (int i = 0; i < NUM_ENCODERS; i++) begin
            ph = PHASE_WALK[31 - 2 * (((j + 4 * i) % 16)) -: 2];
            s.phase_a[i] = ph[1];
            s.phase_b[i] = ph[0];
         end
         // clear on the priming sample and once mid-walk
         s.clear_counts = (j == 0 || j == 9);
         s.read_request = (j % 4 == 1);
         s.ms_tick = (j % 3 != 0);
         send_sample(s);
      end
      s = '{phase_a: 4'hF, phase_b: 4'hF, clear_counts: 1'b0, read_request: 1'b1, ms_tick: 1'b1};
      send_sample(s);
      s = '{phase_a: 4'h0, phase_b: 4'h0, clear_counts: 1'b0, read_request: 1'b0, ms_tick: 1'b0};
      send_sample(s);
      wait_for_reports();
   endtask

   task automatic test_report_priority();
      encoder_sample_type s;
      s = '{phase_a: 4'h5, phase_b: 4'hA, clear_counts: 1'b0, read_request: 1'b0, ms_tick: 1'b0};
      write_register(CSR_UNUSED, 16'hFFFF);
      write_register(CSR_REPORT_INTERVAL, 16'd0);
      write_register(CSR_STREAM_ENABLE, 16'hFFF1);
      // zero interval streams on every transaction
      send_sample(s);
      s.ms_tick = 1'b1;
      send_sample(s);
      wait_for_reports();
      write_register(CSR_REPORT_INTERVAL, 16'd2);
      for (int j = 0; j < 5; j++) begin
         s.phase_a = ~s.phase_a;
         s.ms_tick = (j != 4);
         // read lands where the stream is also due
         s.read_request = (j == 1);
         send_sample(s);
      end
      wait_for_reports();
      write_register(CSR_STREAM_ENABLE, 16'd0);
   endtask

   task automatic test_random_motion();
      logic [NUM_ENCODERS-1:0]   mask;
      logic [INTERVAL_WIDTH-1:0] interval;
      logic                      stream;
      for (int p = 0; p < MOTION_PHASES; p++) begin
         wait_for_reports();
         mask = 4'($urandom);
         interval = 16'($urandom_range(0, 12));
         stream = 1'b1;
         case (p)
            0: begin
               mask = 4'h0;
               interval = 16'd1;
            end
            1: begin
               mask = 4'hF;
               interval = 16'hFFFF;
            end
            2: interval = 16'd0;
            3: begin
               interval = 16'($urandom);
               stream = 1'b0;
               write_register(CSR_UNUSED, 16'($urandom));
            end
            5: stream = 1'b0;
            default: ;
         endcase
         write_register(CSR_REVERSE_MASK, {12'($urandom), mask});
         write_register(CSR_REPORT_INTERVAL, interval);
         write_register(CSR_STREAM_ENABLE, {15'($urandom), stream});
         sender_idles = (p % 4 != 0);
         sink_idles = (p % 3 != 2);
         repeat (MOTION_ITEMS) send_sample(make_motion_sample());
      end
      wait_for_reports();
   endtask

   initial begin : result_sink
      int stall;
      bit hit;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = sink_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         hit = 1'b0;
         while (!hit) begin
            @(negedge clock);
            hit = rsp_if.valid;
            @(posedge clock);
         end
      end
   end

   // outputs and handshakes are stable at the falling edge
   always @(negedge clock) begin
      count_report_type got;
      count_report_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.count[0] = rsp_if.lf_count;
         got.count[1] = rsp_if.rf_count;
         got.count[2] = rsp_if.lr_count;
         got.count[3] = rsp_if.rr_count;
         got.kind = report_kind_type'(rsp_if.report_kind);
         got.stamp = rsp_if.stamp_ms;
         if (pending_reports.size() == 0) begin
            $display("%0t: count report with none expected: expected nothing, actual kind %0d",
                     $time, got.kind);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            kind_tally[want.kind]++;
            for (int i = 0; i < NUM_ENCODERS; i++)
               if (got.count[i] !== want.count[i]) begin
                  $display("%0t: %s count: expected %0d, actual %0d", $time, wheel_name[i],
                           signed'(want.count[i]), signed'(got.count[i]));
                  failures++;
               end
            if (got.kind !== want.kind) begin
               $display("%0t: report_kind: expected %0d, actual %0d", $time, want.kind, got.kind);
               failures++;
            end
            if (got.stamp !== want.stamp) begin
               $display("%0t: stamp_ms: expected %0d, actual %0d", $time, want.stamp,
                        got.stamp);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.phase_a <= '0;
      req_if.phase_b <= '0;
      req_if.clear_counts <= 1'b0;
      req_if.read_request <= 1'b0;
      req_if.ms_tick <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_REVERSE_MASK;
      csr_write_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_transition_table();
      test_report_priority();
      test_random_motion();

      repeat (PIPE_LATENCY + 3) @(posedge clock);
      $display("%0d encoder samples, %0d register writes, %0d results checked",
               samples_sent, csr_writes, reports_checked);
      $display("reports: %0d none, %0d read replies, %0d streamed",
               kind_tally[REPORT_NONE], kind_tally[REPORT_READ], kind_tally[REPORT_STREAM]);
      if (failures == 0 && pending_reports.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results never seen", failures, pending_reports.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/qec_pkg.sv
rtl/qec_req_if.sv
rtl/qec_rsp_if.sv
rtl/qec_channel.sv
rtl/quad_encoder_counter_bank.sv
bench/tb.sv
